// ===== hw/rtl/stbs_pkg.sv =====
`default_nettype none

package stbs_pkg;

  // Table geometry.
  localparam int unsigned TABLE_DEPTH = 256;
  localparam int unsigned KEY_WIDTH   = 16;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W       = IDX_W + 1;

  // Configuration register widths and indexes.
  localparam int unsigned CFG_DATA_W  = 9;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_ORDER   = 1'b1;

  // Request kinds carried in the input tuser bit.
  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_SEARCH = 1'b1;

  // Input tdata layout, lowest bit first.
  localparam int unsigned IN_DATA_W  = IDX_W + 2 * KEY_WIDTH;
  localparam int unsigned IN_TDATA_W = ((IN_DATA_W + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W = ((IDX_W + 7) / 8) * 8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_DONE
  } stbs_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic wr;        // store entry_key at entry_index
    logic load;      // capture the search key, start a new search
    logic rd;        // read the table at the current probe
    logic step;      // apply the comparison to lo and n
    logic res_load;  // move the search result into the output register
  } stbs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic n_zero;    // no entries left to probe
    logic hit;       // probed entry equals the key
    logic out_free;  // output register can take a result this cycle
  } stbs_sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/stbs_ctrl.sv =====
`default_nettype none

module stbs_ctrl import stbs_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  input  wire logic      in_kind_i,
  output logic           in_ready_o,
  input  wire stbs_sts_t sts_i,
  output stbs_cmd_t      cmd_o
);

  stbs_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_kind_i == REQ_SEARCH) begin
            cmd_o.load = 1'b1;
            state_d    = ST_READ;
          end else begin
            cmd_o.wr = 1'b1;
          end
        end
      end
      ST_READ: begin
        // An empty range ends the search without a match.
        if (sts_i.n_zero) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.rd = 1'b1;
          state_d  = ST_CMP;
        end
      end
      ST_CMP: begin
        cmd_o.step = 1'b1;
        state_d    = sts_i.hit ? ST_DONE : ST_READ;
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.res_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/stbs_dpath.sv =====
`default_nettype none

module stbs_dpath import stbs_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic [IDX_W-1:0]      entry_index_i,
  input  wire logic [KEY_WIDTH-1:0]  entry_key_i,
  input  wire logic [KEY_WIDTH-1:0]  search_key_i,
  input  wire stbs_cmd_t             cmd_i,
  output stbs_sts_t                  sts_o,
  input  wire logic                  out_ready_i,
  output logic                       out_valid_o,
  output logic                       found_o,
  output logic [IDX_W-1:0]           match_index_o
);

  logic [CNT_W-1:0]     entry_count_q;
  logic                 key_signed_q;
  logic [KEY_WIDTH-1:0] key_table [TABLE_DEPTH];
  logic [KEY_WIDTH-1:0] rdata_q;
  logic [KEY_WIDTH-1:0] key_q;
  logic [CNT_W-1:0]     lo_q, lo_d;
  logic [CNT_W-1:0]     n_q, n_d;
  logic                 hit_q, hit_d;
  logic [IDX_W-1:0]     hit_idx_q, hit_idx_d;
  logic                 out_valid_q, out_valid_d;
  logic                 found_q;
  logic [IDX_W-1:0]     match_index_q;
  logic [CNT_W-1:0]     n_init;
  logic [IDX_W-1:0]     half;
  logic [IDX_W-1:0]     off;
  logic [CNT_W-1:0]     probe;
  logic [KEY_WIDTH-1:0] cmp_a, cmp_b;
  logic                 key_lt, key_eq;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= '0;
      key_signed_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ENTRY_COUNT: entry_count_q <= cfg_wdata_i[CNT_W-1:0];
        CFG_KEY_ORDER:   key_signed_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Probe position: lo + n/2 for odd n, lo + n/2 - 1 for even n.
  assign half  = n_q[CNT_W-1:1];
  assign off   = n_q[0] ? half : half - IDX_W'(1);
  assign probe = lo_q + CNT_W'(off);

  // Key table: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      key_table[entry_index_i] <= entry_key_i;
    end
    if (cmd_i.rd) begin
      rdata_q <= key_table[probe[IDX_W-1:0]];
    end
  end

  // Signed order is unsigned order with the sign bits flipped.
  assign cmp_a  = {key_q[KEY_WIDTH-1] ^ key_signed_q, key_q[KEY_WIDTH-2:0]};
  assign cmp_b  = {rdata_q[KEY_WIDTH-1] ^ key_signed_q, rdata_q[KEY_WIDTH-2:0]};
  assign key_lt = cmp_a < cmp_b;
  assign key_eq = cmp_a == cmp_b;

  // Entry count saturates at the table depth.
  assign n_init = (entry_count_q > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                       : entry_count_q;

  // Search range update; a single entry left falls out of the same rule.
  always_comb begin
    lo_d      = lo_q;
    n_d       = n_q;
    hit_d     = hit_q;
    hit_idx_d = hit_idx_q;
    if (cmd_i.load) begin
      lo_d      = '0;
      n_d       = n_init;
      hit_d     = 1'b0;
      hit_idx_d = '0;
    end else if (cmd_i.step) begin
      if (key_eq) begin
        hit_d     = 1'b1;
        hit_idx_d = probe[IDX_W-1:0];
      end else if (key_lt) begin
        n_d = CNT_W'(off);
      end else begin
        lo_d = probe + CNT_W'(1);
        n_d  = CNT_W'(half);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q <= search_key_i;
    end
    lo_q      <= lo_d;
    n_q       <= n_d;
    hit_q     <= hit_d;
    hit_idx_q <= hit_idx_d;
  end

  // Output register; a result waits here while the next item is taken.
  assign out_valid_d = cmd_i.res_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      found_q       <= hit_q;
      match_index_q <= hit_idx_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign found_o       = found_q;
  assign match_index_o = match_index_q;

  assign sts_o.n_zero   = (n_q == '0);
  assign sts_o.hit      = key_eq;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

endmodule

`default_nettype wire

// ===== hw/rtl/sorted_table_binary_search.sv =====
// Channel  | Group  | tdata (low bit up)                               | tuser
// ---------+--------+--------------------------------------------------+-----------
// request  | s_axis | entry_index[7:0], entry_key[15:0], search_key    | req_type
// result   | m_axis | match_index[7:0]                                 | found
// config   | cfg_*  | cfg_wdata_i: entry_count (idx 0), key_order (1)  | -
//
// A write is stored as it is accepted. A search is accepted, then runs a table
// read and a compare for each probe, up to 9 probes over 256 entries; it then
// finds the range empty when no probe matched, and finally loads the
// result.
// Reset clears the controller, the configuration and the output valid bit;
// the key table is not cleared and holds garbage until written.
// A stalled result stays in the output register; the next request is taken
// meanwhile, and a finished search waits until that register is free.
`default_nettype none

module sorted_table_binary_search import stbs_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // Configuration write port.
  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata_i,
  // Request stream.
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // Fields: entry_index[7:0], entry_key[23:8], search_key[39:24].
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // Fields: req_type[0].
  input  wire logic                   s_axis_tuser,
  // Result stream.
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // Fields: match_index[7:0].
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
  // Fields: found[0].
  output logic                        m_axis_tuser
);

  stbs_cmd_t        cmd;
  stbs_sts_t        sts;
  logic [IDX_W-1:0] match_index;

  stbs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_kind_i  (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  stbs_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .entry_index_i (s_axis_tdata[IDX_W-1:0]),
    .entry_key_i   (s_axis_tdata[IDX_W+KEY_WIDTH-1:IDX_W]),
    .search_key_i  (s_axis_tdata[IDX_W+2*KEY_WIDTH-1:IDX_W+KEY_WIDTH]),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_ready_i   (m_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .found_o       (m_axis_tuser),
    .match_index_o (match_index)
  );

  assign m_axis_tdata = OUT_TDATA_W'(match_index);

endmodule

`default_nettype wire

// ===== hw/rtl/stbs_checker.sv =====
`default_nettype none

module stbs_checker import stbs_pkg::*; (
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   s_axis_tvalid,
  input wire logic                   s_axis_tready,
  input wire logic                   s_axis_tuser,
  input wire logic                   m_axis_tvalid,
  input wire logic                   m_axis_tready,
  input wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input wire logic                   m_axis_tuser
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // A miss always reports index zero.
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("miss with nonzero index");

  // After a table write the request side is ready again in the next cycle.
  a_write_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == REQ_WRITE |=> s_axis_tready)
    else $error("write did not finish in one cycle");

  // A search keeps the request side closed while it runs.
  a_search_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == REQ_SEARCH |=> !s_axis_tready)
    else $error("request taken during a search");

endmodule

bind sorted_table_binary_search stbs_checker u_stbs_checker (.*);

`default_nettype wire
